// ----- hw/rtl/ppm_pulse_train_decoder_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the PPM pulse train decoder
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef PPM_PULSE_TRAIN_DECODER_UNIT_ASSERT_SVH
`define PPM_PULSE_TRAIN_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ppd_pkg.sv -----
// ---------------------------------------------------------------------------
// ppd_pkg
// Shared constants and types of the PPM pulse train decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

   // channel slots per frame
   localparam int NUM_CHANNELS = 8;

   localparam int SAMPLE_W = 16;
   localparam int WIDTH_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int SYNC_W   = 16;

   // held channel count needs to reach NUM_CHANNELS itself
   localparam int HELD_W = $clog2(NUM_CHANNELS + 1);
   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [SYNC_W-1:0] SYNC_RESET = SYNC_W'(250);

   // frame queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one finished frame handed from front to back
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][WIDTH_W-1:0] widths;
      logic [COUNT_W-1:0]                   count;
      logic [HELD_W-1:0]                    held;
   } frame_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ppd_if.sv -----
// ---------------------------------------------------------------------------
// ppd_req_if / ppd_rsp_if
// Valid/ready channels for samples in and decoded items out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ppd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ppd_pkg::SAMPLE_W-1:0] sample;
   logic                                buffer_end;

   modport source (output valid, output sample, output buffer_end, input ready);
   modport sink   (input valid, input sample, input buffer_end, output ready);
endinterface

interface ppd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ppd_pkg::COUNT_W-1:0]        value;
   logic [ppd_pkg::SLOT_W-1:0]         slot;
   logic                               frame_end;

   modport source (output valid, output value, output slot, output frame_end, input ready);
   modport sink   (input valid, input value, input slot, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppd_front.sv -----
// ---------------------------------------------------------------------------
// ppd_front
// Sample front end: level detect, edge timing, channel capture, frame push.
// ---------------------------------------------------------------------------
`default_nettype none

module ppd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ppd_req_if.sink                            req,
   input  wire logic                          csr_write_enable,
   input  wire logic [ppd_pkg::SYNC_W-1:0]    csr_write_data,
   output logic                               push_valid,
   output ppd_pkg::frame_type                 push_data,
   input  wire logic                          queue_full
);

   logic [ppd_pkg::SYNC_W-1:0]   sync_ff;
   logic                         wire_high_ff;
   logic [ppd_pkg::WIDTH_W-1:0]  peak_latched_ff, peak_latched_in;
   logic [ppd_pkg::WIDTH_W-1:0]  peak_running_ff, peak_running_in;
   logic [ppd_pkg::COUNT_W-1:0]  counter_ff;
   logic [ppd_pkg::COUNT_W-1:0]  last_edge_ff;
   logic [ppd_pkg::HELD_W-1:0]   held_ff, held_in;
   logic [ppd_pkg::NUM_CHANNELS-1:0][ppd_pkg::WIDTH_W-1:0] widths_ff;

   logic                         transfer;
   logic [ppd_pkg::WIDTH_W-1:0]  mag;
   logic                         high;
   logic                         edge_seen;
   logic [ppd_pkg::COUNT_W-1:0]  gap;
   logic                         is_sync;
   logic                         store;
   logic [ppd_pkg::WIDTH_W-1:0]  peak_max;

   assign req.ready = !queue_full;
   assign transfer  = req.valid && req.ready;

   // magnitude; the most negative sample maps to 0x8000
   assign mag  = req.sample[ppd_pkg::SAMPLE_W-1]
               ? ppd_pkg::WIDTH_W'(~req.sample + 1'b1)
               : ppd_pkg::WIDTH_W'(req.sample);
   assign high = {mag, 1'b0} > {1'b0, peak_latched_ff};

   // edge timing
   assign edge_seen = high != wire_high_ff;
   assign gap       = counter_ff - last_edge_ff;
   assign is_sync   = edge_seen && high &&
                      (gap > ppd_pkg::COUNT_W'(sync_ff));
   assign store     = edge_seen && high && !is_sync &&
                      (held_ff < ppd_pkg::HELD_W'(ppd_pkg::NUM_CHANNELS));
   assign held_in   = is_sync ? '0 : (store ? held_ff + 1'b1 : held_ff);

   // peak tracking, latched at buffer end
   assign peak_max        = (mag > peak_running_ff) ? mag : peak_running_ff;
   assign peak_running_in = req.buffer_end ? '0 : peak_max;
   assign peak_latched_in = req.buffer_end ? peak_max : peak_latched_ff;

   // frame snapshot into the queue
   assign push_valid       = transfer && is_sync;
   assign push_data.widths = widths_ff;
   assign push_data.count  = counter_ff;
   assign push_data.held   = held_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff         <= ppd_pkg::SYNC_RESET;
         wire_high_ff    <= 1'b0;
         peak_latched_ff <= '0;
         peak_running_ff <= '0;
         counter_ff      <= '0;
         last_edge_ff    <= '0;
         held_ff         <= '0;
      end else begin
         if (csr_write_enable) begin
            sync_ff <= csr_write_data;
         end
         if (transfer) begin
            wire_high_ff    <= high;
            peak_latched_ff <= peak_latched_in;
            peak_running_ff <= peak_running_in;
            counter_ff      <= counter_ff + 1'b1;
            held_ff         <= held_in;
            if (edge_seen) begin
               last_edge_ff <= counter_ff;
            end
         end
      end
   end

   // channel width store, no reset
   always_ff @(posedge clock) begin
      if (transfer && store) begin
         widths_ff[held_ff[ppd_pkg::IDX_W-1:0]] <= gap[ppd_pkg::WIDTH_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_queue.sv -----
// ---------------------------------------------------------------------------
// ppd_queue
// Short frame queue between the sample front end and the item emitter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ppm_pulse_train_decoder_unit_assert.svh"

module ppd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire ppd_pkg::frame_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output ppd_pkg::frame_type      head,
   output logic                    empty
);

   ppd_pkg::frame_type            entries_ff [ppd_pkg::QUEUE_DEPTH];
   logic [ppd_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [ppd_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [ppd_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full  = count_ff == ppd_pkg::QCNT_W'(ppd_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == ppd_pkg::QPTR_W'(ppd_pkg::QUEUE_DEPTH - 1))
                       ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == ppd_pkg::QPTR_W'(ppd_pkg::QUEUE_DEPTH - 1))
                       ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PPD_ASSERT_IMPL(a_no_overflow, push_valid, !full, "frame pushed into full queue")
   `PPD_ASSERT_IMPL(a_no_underflow, pop, !empty, "frame popped from empty queue")
   `PPD_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= ppd_pkg::QCNT_W'(ppd_pkg::QUEUE_DEPTH), "queue count out of range")
   `PPD_ASSERT_NEXT(a_push_lands, push_valid && !pop, !empty, "pushed frame not held")

endmodule

`default_nettype wire

// ----- hw/rtl/ppd_back.sv -----
// ---------------------------------------------------------------------------
// ppd_back
// Item emitter: walks one queued frame into width items and an end item.
// ---------------------------------------------------------------------------
`default_nettype none

module ppd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ppd_pkg::frame_type head,
   input  wire logic               empty,
   output logic                    pop,
   ppd_rsp_if.source               rsp
);

   logic [ppd_pkg::HELD_W-1:0]   idx_ff;
   logic                         valid_ff;
   logic [ppd_pkg::COUNT_W-1:0]  value_ff;
   logic [ppd_pkg::SLOT_W-1:0]   slot_ff;
   logic                         end_ff;

   logic                         advance;
   logic                         last_item;
   logic [ppd_pkg::COUNT_W-1:0]  value_in;
   logic [ppd_pkg::SLOT_W-1:0]   slot_in;

   assign advance   = !empty && (!valid_ff || rsp.ready);
   assign last_item = idx_ff >= head.held;
   assign pop       = advance && last_item;

   // next item of the frame at the head
   assign value_in = last_item
                   ? head.count
                   : ppd_pkg::COUNT_W'(head.widths[idx_ff[ppd_pkg::IDX_W-1:0]]);
   assign slot_in  = last_item ? ppd_pkg::SLOT_W'(head.held) : ppd_pkg::SLOT_W'(idx_ff);

   // output register and walk index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            idx_ff   <= last_item ? '0 : idx_ff + 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // output payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
         end_ff   <= last_item;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.value     = value_ff;
   assign rsp.slot      = slot_ff;
   assign rsp.frame_end = end_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ppm_pulse_train_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// ppm_pulse_train_decoder_unit
// PPM pulse train decoder: samples in, channel widths and frame ends out.
// ---------------------------------------------------------------------------
// Usage:
//  req_bus carries one signed 16-bit sample per transfer plus buffer_end.
//  rsp_bus carries decoded items: value, slot and frame_end.
//  csr_write_enable / csr_write_data set the sync gap width (reset 250);
//  write only while the block is idle.
//  Samples are taken one per cycle while the two-entry frame queue has room.
//  A sample that detects frame sync pushes a frame snapshot into the queue;
//  its items reach rsp_bus through the queue entry and then the output register.
//  A frame with k stored channels yields k+1 items, one per cycle while
//  the receiver is ready, as the emitter walks one queue entry item by item.
//  When the receiver stalls, the output register holds and the queue fills;
//  req_bus.ready drops only while both queue entries are occupied.
//  Reset (synchronous, active high) clears counters, peaks, level, channel
//  count, queue and output; channel width storage is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module ppm_pulse_train_decoder_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ppd_req_if.sink                          req_bus,
   ppd_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_write_enable,
   input  wire logic [ppd_pkg::SYNC_W-1:0]  csr_write_data
);

   logic               push_valid;
   ppd_pkg::frame_type push_data;
   logic               queue_full;
   logic               pop;
   ppd_pkg::frame_type head;
   logic               queue_empty;

   ppd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .queue_full       (queue_full)
   );

   ppd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   ppd_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (queue_empty),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- sim/tb_ppm_pulse_train_decoder_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ppm_pulse_train_decoder_unit
// Self-checking bench for the PPM pulse train decoder. A scoreboard class
// tracks level, peaks, edge counts and stored channel widths per accepted
// sample, and queues the decoded items each sync should release. Samples
// are mostly well-formed pulse trains built against the tracked peak, plus
// random noise, under several sync widths, random stalls on both channels,
// a long receiver hold-off and a slot-overflow frame.
// ---------------------------------------------------------------------------

module tb_ppm_pulse_train_decoder_unit;

   // cycles the block may still be busy after the last item has left
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [ppd_pkg::COUNT_W-1:0] value;
      logic [ppd_pkg::SLOT_W-1:0]  slot;
      logic                        frame_end;
   } decoded_item_type;

   // -------------------------------------------------------------------------
   // Scoreboard: decoder state plus the queue of items still owed
   // -------------------------------------------------------------------------
   class ppm_frame_scoreboard;
      logic [ppd_pkg::SYNC_W-1:0]   sync_gap;
      logic                         level_high;
      logic [ppd_pkg::SAMPLE_W-1:0] peak_hold;
      logic [ppd_pkg::SAMPLE_W-1:0] peak_run;
      logic [ppd_pkg::COUNT_W-1:0]  sample_count;
      logic [ppd_pkg::COUNT_W-1:0]  edge_count;
      logic [ppd_pkg::SLOT_W-1:0]   held;
      logic [ppd_pkg::WIDTH_W-1:0]  widths [ppd_pkg::NUM_CHANNELS];
      decoded_item_type             owed_items [$];
      int                           mismatches;
      int                           checked;
      int                           predicted;

      function new();
         sync_gap     = ppd_pkg::SYNC_RESET;
         level_high   = 1'b0;
         peak_hold    = '0;
         peak_run     = '0;
         sample_count = '0;
         edge_count   = '0;
         held         = '0;
         foreach (widths[i]) widths[i] = '0;
         mismatches   = 0;
         checked      = 0;
         predicted    = 0;
      endfunction

      function void set_sync(logic [ppd_pkg::SYNC_W-1:0] gap_width);
         sync_gap = gap_width;
      endfunction

      function int pending();
         return owed_items.size();
      endfunction

      function void owe(logic [ppd_pkg::COUNT_W-1:0] value, logic [ppd_pkg::SLOT_W-1:0] slot,
                        logic frame_end);
         decoded_item_type item;
         item.value     = value;
         item.slot      = slot;
         item.frame_end = frame_end;
         owed_items.push_back(item);
         predicted++;
      endfunction

      // one accepted sample: level test, edge handling, peak tracking
      function void take_sample(logic signed [ppd_pkg::SAMPLE_W-1:0] s, logic last_of_buffer);
         logic [ppd_pkg::SAMPLE_W:0]  mag;
         logic                        is_high;
         logic [ppd_pkg::COUNT_W-1:0] gap;
         mag     = s[ppd_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
         is_high = {mag, 1'b0} > {2'b00, peak_hold};
         if (is_high != level_high) begin
            gap        = sample_count - edge_count;
            level_high = is_high;
            if (is_high) begin
               if (gap > {16'd0, sync_gap}) begin
                  // frame sync: dump stored widths, then the count item
                  for (int i = 0; i < held; i++)
                     owe(ppd_pkg::COUNT_W'(widths[ppd_pkg::IDX_W'(i)]), ppd_pkg::SLOT_W'(i),
                         1'b0);
                  owe(sample_count, held, 1'b1);
                  held = '0;
               end else if (held < ppd_pkg::NUM_CHANNELS) begin
                  widths[held[ppd_pkg::IDX_W-1:0]] = gap[ppd_pkg::WIDTH_W-1:0];
                  held++;
               end
            end
            edge_count = sample_count;
         end
         if (mag > {1'b0, peak_run}) peak_run = mag[ppd_pkg::SAMPLE_W-1:0];
         sample_count++;
         if (last_of_buffer) begin
            peak_hold = peak_run;
            peak_run  = '0;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         // keep the log bounded on a badly broken build
         if (mismatches <= 100)
            $display("mismatch %0d at %0t: %s", mismatches, $time, what);
      endtask

      task check_item(logic [ppd_pkg::COUNT_W-1:0] value, logic [ppd_pkg::SLOT_W-1:0] slot,
                      logic frame_end);
         decoded_item_type want;
         if (owed_items.size() == 0) begin
            report_mismatch($sformatf("unexpected item value=%0d slot=%0d end=%0b",
                                      value, slot, frame_end));
         end else begin
            want = owed_items.pop_front();
            checked++;
            if (value !== want.value)
               report_mismatch($sformatf("value %0d, want %0d", value, want.value));
            if (slot !== want.slot)
               report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
            if (frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %0b, want %0b", frame_end,
                                         want.frame_end));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and block
   // -------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [ppd_pkg::SYNC_W-1:0] csr_write_data;

   ppd_req_if req_bus ();
   ppd_rsp_if rsp_bus ();

   ppm_pulse_train_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ppm_frame_scoreboard sb = new();

   int req_idle_pct = 35;
   int rsp_idle_pct = 86;
   int hold_left    = 0;
   int samples_sent = 0;
   int syncs_written = 0;
   int sync_now     = int'(ppd_pkg::SYNC_RESET);

   // opening samples: full-scale extremes, zero, +-1, peak latching and the
   // level threshold right at half the latched peak
   logic signed [ppd_pkg::SAMPLE_W-1:0] opening_samples [15] = '{
      16'sd0, 16'sh8000, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd16384,
      -16'sd16384, 16'sd16385, -16'sd16385, 16'sd0, 16'sd8193, -16'sd8192,
      16'sd32767, 16'sd0
   };
   logic opening_ends [15] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                               1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

   // -------------------------------------------------------------------------
   // Result side: check each transfer, random stalls, counted hold-off
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_item(rsp_bus.value, rsp_bus.slot, rsp_bus.frame_end);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sample side
   // -------------------------------------------------------------------------
   task automatic send_sample(logic signed [ppd_pkg::SAMPLE_W-1:0] s, logic last_of_buffer);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= s;
      req_bus.buffer_end <= last_of_buffer;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
      sb.take_sample(s, last_of_buffer);
   endtask

   // sample that lands high or low against the currently latched peak
   function automatic logic signed [ppd_pkg::SAMPLE_W-1:0] level_sample(bit want_high);
      int unsigned half;
      int unsigned mag;
      half = sb.peak_hold / 2;
      mag  = want_high ? $urandom_range(32768, half + 1) : $urandom_range(half, 0);
      if (mag == 32768) return 16'sh8000;
      if ($urandom_range(1)) return -$signed(ppd_pkg::SAMPLE_W'(mag));
      return ppd_pkg::SAMPLE_W'(mag);
   endfunction

   task automatic send_level(bit want_high, int count);
      repeat (count) send_sample(level_sample(want_high), $urandom_range(11) == 0);
   endtask

   task automatic send_noise(int count);
      repeat (count) send_sample(ppd_pkg::SAMPLE_W'($urandom()), 1'($urandom_range(1)));
   endtask

   // one frame: leading pulse, 0..10 channels, then a gap at or past sync
   task automatic send_frame();
      int channels;
      int gap;
      send_level(1'b1, $urandom_range(3, 1));
      channels = $urandom_range(10, 0);
      repeat (channels) begin
         send_level(1'b0, $urandom_range(sync_now, 1));
         send_level(1'b1, $urandom_range(2, 1));
      end
      gap = ($urandom_range(4) == 0) ? sync_now : sync_now + $urandom_range(3, 1);
      send_level(1'b0, gap);
   endtask

   task automatic run_frames(int min_samples, int min_items);
      int first_sample;
      int first_item;
      first_sample = samples_sent;
      first_item   = sb.predicted;
      while (samples_sent - first_sample < min_samples ||
             sb.predicted - first_item < min_items) begin
         if ($urandom_range(5) == 0) send_noise($urandom_range(6, 1));
         else send_frame();
      end
   endtask

   // stop offering, wait for every owed item, then let the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(logic [ppd_pkg::SYNC_W-1:0] gap_width);
      csr_write_enable <= 1'b1;
      csr_write_data   <= gap_width;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_sync(gap_width);
      sync_now = int'(gap_width);
      syncs_written++;
   endtask

   task automatic random_phase();
      settle();
      write_sync(ppd_pkg::SYNC_W'($urandom_range(6, 1)));
      run_frames(25, 6);
   endtask

   // -------------------------------------------------------------------------
   // Run sequence
   // -------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.sample     <= '0;
      req_bus.buffer_end <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening at the reset sync width
      foreach (opening_samples[i]) send_sample(opening_samples[i], opening_ends[i]);

      // sync width zero: every rising edge is a sync, many empty frames
      settle();
      write_sync('0);
      send_noise(40);

      // widest sync: never reached, so slots fill and extra channels drop
      settle();
      write_sync('1);
      send_level(1'b1, 1);
      repeat (11) begin
         send_level(1'b0, $urandom_range(8, 1));
         send_level(1'b1, 1);
      end
      send_level(1'b0, 3);

      // narrow sync releases the full frame of eight widths plus its count
      settle();
      write_sync(ppd_pkg::SYNC_W'(2));
      send_level(1'b1, 1);

      random_phase();
      random_phase();

      req_idle_pct = 86;
      rsp_idle_pct = 35;
      random_phase();
      random_phase();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_phase();
      random_phase();

      // receiver holds off while short frames pile into the queue
      settle();
      write_sync(ppd_pkg::SYNC_W'(1));
      hold_left = 250;
      run_frames(80, 0);

      settle();
      $display("covered %0d samples under %0d sync settings (0, 65535, 1..6 and reset)",
               samples_sent, syncs_written + 1);
      $display("checked %0d decoded items incl. slot overflow, empty frames, backpressure",
               sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // run limit
   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

// ----- ppm_pulse_train_decoder_unit.f -----
+incdir+hw/rtl
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_if.sv
hw/rtl/ppd_front.sv
hw/rtl/ppd_queue.sv
hw/rtl/ppd_back.sv
hw/rtl/ppm_pulse_train_decoder_unit.sv
sim/tb_ppm_pulse_train_decoder_unit.sv
